### hdl/abmh_pkg.sv
// Shared types, codes and helpers for the accessory bus message handler.
`timescale 1ns / 1ps
`default_nettype none

package abmh_pkg;

  // Request kinds on the input channel
  localparam logic [2:0] REQ_RX_BYTE  = 3'd0;
  localparam logic [2:0] REQ_READ     = 3'd1;
  localparam logic [2:0] REQ_FEEDBACK = 3'd2;
  localparam logic [2:0] REQ_POWER    = 3'd3;
  localparam logic [2:0] REQ_TURNOUT  = 3'd4;

  // Received header bytes
  localparam logic [7:0] HDR_ACC_INFO  = 8'h42;
  localparam logic [7:0] HDR_BCAST     = 8'h61;
  localparam logic [7:0] HDR_ESTOP     = 8'h81;
  localparam logic [7:0] HDR_STATUS    = 8'h62;
  localparam logic [7:0] ID_STATUS     = 8'h22;
  localparam logic [7:0] ID_TRACK_OFF  = 8'h00;
  localparam logic [7:0] ID_TRACK_ON   = 8'h01;
  localparam logic [7:0] ID_PROG_MODE  = 8'h02;
  localparam logic [7:0] ID_BUSY       = 8'h81;
  localparam logic [7:0] STATUS_OFF_MASK = 8'h4B;

  // Transmitted message bytes
  localparam logic [7:0] TX_ACC_INFO_REQ = 8'h42;
  localparam logic [7:0] TX_ACC_OP       = 8'h52;
  localparam logic [7:0] TX_STATUS_HDR   = 8'h21;
  localparam logic [7:0] TX_STATUS_ID    = 8'h24;
  localparam logic [7:0] TX_LO_BASE      = 8'h80;
  localparam logic [7:0] TX_LO_PRESS     = 8'h88;

  // Turnout states as held in the table
  localparam logic [1:0] TURN_UNKNOWN = 2'd0;
  localparam logic [1:0] TURN_PLUS    = 2'd1;
  localparam logic [1:0] TURN_MINUS   = 2'd2;

  // Kind of outgoing run for one request
  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_FEEDBACK,
    KIND_POWER,
    KIND_TURNOUT
  } kind_t;

  // Result descriptor handed from the decode stage to the transmit sequencer
  typedef struct packed {
    kind_t      kind;
    logic [7:0] hi;        // address high byte
    logic [2:0] lo;        // low address bits (and direction for turnouts)
    logic       power;
    logic       answered;
    logic       busy;
    logic       tread;     // table read in range
    logic       tsel;      // odd entry of the row
  } res_t;

  // Number of results for each kind
  function automatic logic [2:0] res_count(kind_t k);
    logic [2:0] n;
    unique case (k)
      KIND_FEEDBACK: n = 3'd3;
      KIND_POWER:    n = 3'd2;
      KIND_TURNOUT:  n = 3'd6;
      default:       n = 3'd1;
    endcase
    return n;
  endfunction

  // Feedback code on the bus to table state
  function automatic logic [1:0] decode_state(logic [1:0] code);
    logic [1:0] v;
    unique case (code)
      2'd1:    v = TURN_MINUS;
      2'd2:    v = TURN_PLUS;
      default: v = TURN_UNKNOWN;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

### hdl/abmh_core.sv
// Receive decoding, request tracking and the turnout state table.
`timescale 1ns / 1ps
`default_nettype none

module abmh_core #(
  parameter int TABLE_ENTRIES = 1024,
  parameter int MAX_MSG_BYTES = 64
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             adv,
  input  wire logic [2:0]       req_type,
  input  wire logic [7:0]       rx_byte,
  input  wire logic             rx_end,
  input  wire logic [10:0]      accessory_number,
  input  wire logic             turn_direction,
  output abmh_pkg::res_t        desc,
  output logic [3:0]            rd_row,
  output logic                  clr_busy
);
  import abmh_pkg::*;

  localparam int ROWS  = (TABLE_ENTRIES + 1) / 2;
  localparam int ROW_W = $clog2(ROWS);
  localparam int POS_W = $clog2(MAX_MSG_BYTES + 1);

  logic [POS_W-1:0] pos_r, pos_nxt, pos_inc;
  logic [7:0]       head_r [3];
  logic [7:0]       head_nxt [3];
  logic [7:0]       hold_r [2];
  logic [7:0]       hold_nxt [2];
  logic             power_r, power_nxt;
  logic             pend_r, pend_nxt;
  logic             pend_pwr_r, pend_pwr_nxt;
  logic [8:0]       pend_mod_r, pend_mod_nxt;
  logic             busy;
  logic             pair_wr;

  logic [9:0]       acc;
  logic [8:0]       pair_mod;
  logic             pair_in_range;
  logic [ROW_W-1:0] rd_addr;

  logic [3:0]       mem [ROWS];
  logic [3:0]       rd_row_r;
  logic             clr_r;
  logic [ROW_W-1:0] clr_idx_r;

  // Zero-based accessory number, wraps modulo 1024
  assign acc           = 10'(accessory_number - 11'd1);
  assign pair_mod      = {hold_r[0], hold_r[1][4]};
  assign pair_in_range = ({1'b0, pair_mod} < 10'(ROWS));
  assign rd_addr       = acc[ROW_W:1];

  // Next state and result descriptor
  always_comb begin
    pos_nxt      = pos_r;
    pos_inc      = pos_r;
    head_nxt     = head_r;
    hold_nxt     = hold_r;
    power_nxt    = power_r;
    pend_nxt     = pend_r;
    pend_pwr_nxt = pend_pwr_r;
    pend_mod_nxt = pend_mod_r;
    busy         = 1'b0;
    pair_wr      = 1'b0;
    desc         = '0;
    desc.kind    = KIND_NONE;
    desc.hi      = acc[9:2];
    desc.lo      = {acc[1:0], turn_direction};
    desc.tsel    = acc[0];
    unique case (req_type)
      REQ_RX_BYTE: begin
        if (pos_r < POS_W'(MAX_MSG_BYTES)) begin
          for (int k = 0; k < 3; k++) begin
            if (pos_r == POS_W'(k)) head_nxt[k] = rx_byte;
          end
          if (pos_r != '0) begin
            if (pos_r[0]) begin
              // previous pair is complete once the next byte shows up
              if (pos_r >= POS_W'(3) && head_r[0] == HDR_ACC_INFO) begin
                pair_wr = 1'b1;
                if (pend_r && !pend_pwr_r && pend_mod_r == pair_mod) pend_nxt = 1'b0;
              end
              hold_nxt[0] = rx_byte;
            end else begin
              hold_nxt[1] = rx_byte;
            end
          end
          pos_inc = pos_r + POS_W'(1);
        end
        pos_nxt = pos_inc;
        if (rx_end) begin
          pos_nxt = '0;
          // three byte broadcasts
          if (pos_inc == POS_W'(3)) begin
            if (head_r[0] == HDR_BCAST && head_r[1] == ID_TRACK_OFF) power_nxt = 1'b0;
            if (head_r[0] == HDR_BCAST && head_r[1] == ID_TRACK_ON)  power_nxt = 1'b1;
            if (head_r[0] == HDR_ESTOP && head_r[1] == ID_TRACK_OFF) power_nxt = 1'b0;
            if (head_r[0] == HDR_BCAST && head_r[1] == ID_PROG_MODE) power_nxt = 1'b0;
            if (head_r[0] == HDR_BCAST && head_r[1] == ID_BUSY)      busy = 1'b1;
          end
          // status reply
          if (pos_inc == POS_W'(4) && head_r[0] == HDR_STATUS && head_r[1] == ID_STATUS) begin
            if (pend_r && pend_pwr_r) pend_nxt = 1'b0;
            power_nxt = ((head_r[2] & STATUS_OFF_MASK) == 8'h00);
          end
        end
      end
      REQ_READ: begin
        desc.tread = ({1'b0, acc} < 11'(TABLE_ENTRIES));
      end
      REQ_FEEDBACK: begin
        desc.kind    = KIND_FEEDBACK;
        desc.lo      = {2'b00, acc[1]};
        pend_nxt     = 1'b1;
        pend_pwr_nxt = 1'b0;
        pend_mod_nxt = acc[9:1];
      end
      REQ_POWER: begin
        desc.kind    = KIND_POWER;
        pend_nxt     = 1'b1;
        pend_pwr_nxt = 1'b1;
      end
      REQ_TURNOUT: begin
        if (power_r) desc.kind = KIND_TURNOUT;
      end
      default: begin
      end
    endcase
    desc.power    = power_nxt;
    desc.answered = !pend_nxt;
    desc.busy     = busy;
  end

  // Decode state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      head_r     <= '{default: 8'h00};
      hold_r     <= '{default: 8'h00};
      power_r    <= 1'b0;
      pend_r     <= 1'b0;
      pend_pwr_r <= 1'b0;
      pend_mod_r <= '0;
    end else if (adv) begin
      pos_r      <= pos_nxt;
      head_r     <= head_nxt;
      hold_r     <= hold_nxt;
      power_r    <= power_nxt;
      pend_r     <= pend_nxt;
      pend_pwr_r <= pend_pwr_nxt;
      pend_mod_r <= pend_mod_nxt;
    end
  end

  // Clearing pass over the table after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r     <= 1'b1;
      clr_idx_r <= '0;
    end else if (clr_r) begin
      clr_idx_r <= clr_idx_r + ROW_W'(1);
      if (clr_idx_r == ROW_W'(ROWS - 1)) clr_r <= 1'b0;
    end
  end

  // Turnout table, one row per module (two entries)
  always_ff @(posedge clk) begin
    if (clr_r) begin
      mem[clr_idx_r] <= '0;
    end else if (adv && pair_wr && pair_in_range) begin
      mem[pair_mod[ROW_W-1:0]] <= {decode_state(hold_r[1][3:2]),
                                   decode_state(hold_r[1][1:0])};
    end
    if (adv) rd_row_r <= mem[rd_addr];
  end

  assign rd_row   = rd_row_r;
  assign clr_busy = clr_r;

endmodule

`default_nettype wire

### hdl/abmh_tx_seq.sv
// Result register and sequencer that emits the results of one request.
`timescale 1ns / 1ps
`default_nettype none

module abmh_tx_seq (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           load,
  input  wire abmh_pkg::res_t desc_in,
  input  wire logic [3:0]     rd_row,
  output logic                free,
  output logic                out_valid,
  input  wire logic           out_stall,
  output logic                out_tx_valid,
  output logic [7:0]          out_tx_byte,
  output logic                out_tx_msg_end,
  output logic [1:0]          out_turnout_value,
  output logic                out_power_flag,
  output logic                out_request_answered,
  output logic                out_busy_pulse,
  output logic                out_run_last
);
  import abmh_pkg::*;

  logic       s2_valid_r;
  res_t       desc_r;
  logic [2:0] idx_r;
  logic       last;

  assign last = (idx_r == res_count(desc_r.kind) - 3'd1);
  assign free = !s2_valid_r || (!out_stall && last);

  // Result register and run index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      idx_r      <= '0;
    end else if (load) begin
      s2_valid_r <= 1'b1;
      idx_r      <= '0;
    end else if (s2_valid_r && !out_stall) begin
      if (last) s2_valid_r <= 1'b0;
      else      idx_r      <= idx_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) desc_r <= desc_in;
  end

  // Byte selection for the current position in the run
  always_comb begin
    out_tx_byte    = 8'h00;
    out_tx_msg_end = 1'b0;
    unique case (desc_r.kind)
      KIND_FEEDBACK: begin
        unique case (idx_r)
          3'd0:    out_tx_byte = TX_ACC_INFO_REQ;
          3'd1:    out_tx_byte = desc_r.hi;
          default: begin
            out_tx_byte    = TX_LO_BASE | {5'd0, desc_r.lo};
            out_tx_msg_end = 1'b1;
          end
        endcase
      end
      KIND_POWER: begin
        if (idx_r == 3'd0) begin
          out_tx_byte = TX_STATUS_HDR;
        end else begin
          out_tx_byte    = TX_STATUS_ID;
          out_tx_msg_end = 1'b1;
        end
      end
      KIND_TURNOUT: begin
        unique case (idx_r)
          3'd0, 3'd3: out_tx_byte = TX_ACC_OP;
          3'd1, 3'd4: out_tx_byte = desc_r.hi;
          3'd2: begin
            out_tx_byte    = TX_LO_PRESS | {5'd0, desc_r.lo};
            out_tx_msg_end = 1'b1;
          end
          default: begin
            out_tx_byte    = TX_LO_BASE | {5'd0, desc_r.lo};
            out_tx_msg_end = 1'b1;
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  assign out_valid            = s2_valid_r;
  assign out_tx_valid         = (desc_r.kind != KIND_NONE);
  assign out_turnout_value    = !desc_r.tread ? TURN_UNKNOWN :
                                (desc_r.tsel ? rd_row[3:2] : rd_row[1:0]);
  assign out_power_flag       = desc_r.power;
  assign out_request_answered = desc_r.answered;
  assign out_busy_pulse       = desc_r.busy;
  assign out_run_last         = last;

endmodule

`default_nettype wire

### hdl/accessory_bus_message_handler.sv
// Top level of the accessory bus message handler.
// Requests enter an input register, are decoded in one pass into a result register and then
// leave as a run of results: one for a received byte, a table read, an idle turnout action or
// an unused code, two for a power request, three for a feedback request and six for a turnout
// action with power on. A new request is taken every cycle while runs are one result long and
// out_stall is low; otherwise the output sequencer sets the rate at one result per cycle while
// out_stall is low, and a request holds the block until its run is through. A request passes
// the input register and then the result register before its first result shows. After reset
// the turnout table (two entries per row) is cleared row by row, during which in_stall is high.
`timescale 1ns / 1ps
`default_nettype none

module accessory_bus_message_handler #(
  parameter int TABLE_ENTRIES = 1024,
  parameter int MAX_MSG_BYTES = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  in_req_type,
  input  wire logic [7:0]  in_rx_byte,
  input  wire logic        in_rx_end,
  input  wire logic [10:0] in_accessory_number,
  input  wire logic        in_turn_direction,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_tx_valid,
  output logic [7:0]       out_tx_byte,
  output logic             out_tx_msg_end,
  output logic [1:0]       out_turnout_value,
  output logic             out_power_flag,
  output logic             out_request_answered,
  output logic             out_busy_pulse,
  output logic             out_run_last
);
  import abmh_pkg::*;

  logic        s1_valid_r;
  logic [2:0]  s1_req_r;
  logic [7:0]  s1_rx_byte_r;
  logic        s1_rx_end_r;
  logic [10:0] s1_num_r;
  logic        s1_dir_r;

  logic        accept;
  logic        adv;
  logic        s2_free;
  logic        clr_busy;
  res_t        desc;
  logic [3:0]  rd_row;

  // Handshake: take a request while the table is not being cleared and the input register is empty or moving on
  assign adv      = s1_valid_r && s2_free;
  assign in_stall = clr_busy || (s1_valid_r && !s2_free);
  assign accept   = in_valid && !in_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_req_r     <= in_req_type;
      s1_rx_byte_r <= in_rx_byte;
      s1_rx_end_r  <= in_rx_end;
      s1_num_r     <= in_accessory_number;
      s1_dir_r     <= in_turn_direction;
    end
  end

  abmh_core #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .MAX_MSG_BYTES (MAX_MSG_BYTES)
  ) u_core (
    .clk              (clk),
    .rst_n            (rst_n),
    .adv              (adv),
    .req_type         (s1_req_r),
    .rx_byte          (s1_rx_byte_r),
    .rx_end           (s1_rx_end_r),
    .accessory_number (s1_num_r),
    .turn_direction   (s1_dir_r),
    .desc             (desc),
    .rd_row           (rd_row),
    .clr_busy         (clr_busy)
  );

  abmh_tx_seq u_tx_seq (
    .clk                  (clk),
    .rst_n                (rst_n),
    .load                 (adv),
    .desc_in              (desc),
    .rd_row               (rd_row),
    .free                 (s2_free),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_tx_valid         (out_tx_valid),
    .out_tx_byte          (out_tx_byte),
    .out_tx_msg_end       (out_tx_msg_end),
    .out_turnout_value    (out_turnout_value),
    .out_power_flag       (out_power_flag),
    .out_request_answered (out_request_answered),
    .out_busy_pulse       (out_busy_pulse),
    .out_run_last         (out_run_last)
  );

endmodule

`default_nettype wire

### hdl/abmh_checker.sv
// Port level checks for the accessory bus message handler, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module abmh_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic        out_tx_valid,
  input wire logic [7:0]  out_tx_byte,
  input wire logic        out_tx_msg_end,
  input wire logic [1:0]  out_turnout_value,
  input wire logic        out_busy_pulse,
  input wire logic        out_run_last
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_tx_byte) && $stable(out_run_last))
    else $error("stalled result changed");

  // A result without a byte stands alone and carries no byte
  a_idle_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_tx_valid |-> out_tx_byte == 8'h00 && !out_tx_msg_end && out_run_last)
    else $error("empty result malformed");

  // Every run of bytes closes with a message end
  a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_tx_valid && out_run_last |-> out_tx_msg_end)
    else $error("run ended inside a message");

  // Results never show the unused turnout code
  a_turn_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_turnout_value != 2'd3)
    else $error("bad turnout value");

  // Busy pulses come only from received bytes
  a_busy_rx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_busy_pulse |-> !out_tx_valid && out_turnout_value == 2'd0)
    else $error("busy pulse on a non-receive result");

endmodule

bind accessory_bus_message_handler abmh_checker u_abmh_checker (.*);

`default_nettype wire

### test/accessory_bus_message_handler_tb.sv
// Self-checking testbench for the accessory bus message handler: scoreboard and stimulus.
`timescale 1ns / 1ps

package abmh_tb_pkg;
  import abmh_pkg::*;

  // Request codes that the block takes but ignores
  localparam logic [2:0] REQ_UNUSED_LO = 3'd5;
  localparam logic [2:0] REQ_UNUSED_HI = 3'd7;

  // One request as it crossed the input channel
  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  rx_byte;
    logic        rx_end;
    logic [10:0] acc_num;
    logic        dir;
  } bus_req_t;

  // One word on the result channel
  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       tx_msg_end;
    logic [1:0] turnout_value;
    logic       power_flag;
    logic       answered;
    logic       busy;
    logic       run_last;
  } bus_result_t;

  class accessory_bus_scoreboard;
    int errors;
    bus_result_t awaited_results[$];

    // Mirror of the block's decoder state
    int         msg_len;
    logic [7:0] head [3];
    logic [7:0] held_pair [2];
    logic       power_on;
    logic       req_open;
    logic       req_is_power;
    logic [8:0] req_module;
    logic [1:0] turnout_states [1024];

    function new();
      errors       = 0;
      msg_len      = 0;
      power_on     = 1'b0;
      req_open     = 1'b0;
      req_is_power = 1'b0;
      req_module   = '0;
      foreach (head[i]) head[i] = '0;
      foreach (held_pair[i]) held_pair[i] = '0;
      foreach (turnout_states[i]) turnout_states[i] = TURN_UNKNOWN;
    endfunction

    function int waiting();
      return awaited_results.size();
    endfunction

    // Bus feedback code to table state: 1 is minus, 2 is plus
    function logic [1:0] turnout_from_code(logic [1:0] code);
      if (code == 2'd1) return TURN_MINUS;
      if (code == 2'd2) return TURN_PLUS;
      return TURN_UNKNOWN;
    endfunction

    // A feedback pair covers one module, i.e. two table entries
    function void store_pair(logic [7:0] d1, logic [7:0] d2);
      logic [8:0] module_idx;
      module_idx = {d1, d2[4]};
      if (req_open && !req_is_power && req_module == module_idx) req_open = 1'b0;
      turnout_states[{module_idx, 1'b0}] = turnout_from_code(d2[1:0]);
      turnout_states[{module_idx, 1'b1}] = turnout_from_code(d2[3:2]);
    endfunction

    // Whole-message decode once the last byte is in
    function void close_message(output logic busy);
      busy = 1'b0;
      if (msg_len == 3) begin
        if (head[0] == HDR_BCAST && head[1] == ID_TRACK_OFF) power_on = 1'b0;
        if (head[0] == HDR_BCAST && head[1] == ID_TRACK_ON) power_on = 1'b1;
        if (head[0] == HDR_ESTOP && head[1] == ID_TRACK_OFF) power_on = 1'b0;
        if (head[0] == HDR_BCAST && head[1] == ID_PROG_MODE) power_on = 1'b0;
        if (head[0] == HDR_BCAST && head[1] == ID_BUSY) busy = 1'b1;
      end
      if (msg_len == 4 && head[0] == HDR_STATUS && head[1] == ID_STATUS) begin
        if (req_open && req_is_power) req_open = 1'b0;
        power_on = ((head[2] & STATUS_OFF_MASK) == 8'h00);
      end
    endfunction

    // Byte intake; a pair is applied only when the byte after it arrives
    function void take_byte(logic [7:0] b, logic last, output logic busy);
      busy = 1'b0;
      if (msg_len < 64) begin
        if (msg_len < 3) head[msg_len] = b;
        if (msg_len >= 1) begin
          if (msg_len % 2 == 1) begin
            if (msg_len >= 3 && head[0] == HDR_ACC_INFO) store_pair(held_pair[0], held_pair[1]);
            held_pair[0] = b;
          end else begin
            held_pair[1] = b;
          end
        end
        msg_len++;
      end
      if (last) begin
        close_message(busy);
        msg_len = 0;
      end
    endfunction

    function bus_result_t tx_word(logic [7:0] b, logic msg_end);
      bus_result_t w;
      w = '0;
      w.tx_valid   = 1'b1;
      w.tx_byte    = b;
      w.tx_msg_end = msg_end;
      return w;
    endfunction

    // Work out the run of results that one accepted request causes
    function void apply_request(bus_req_t r);
      logic [9:0]  idx;
      logic [2:0]  lo;
      logic [1:0]  tval;
      logic        busy;
      bus_result_t run[$];
      idx  = 10'(r.acc_num - 11'd1);
      lo   = {idx[1:0], r.dir};
      tval = TURN_UNKNOWN;
      busy = 1'b0;
      case (r.kind)
        REQ_RX_BYTE: take_byte(r.rx_byte, r.rx_end, busy);
        REQ_READ: tval = turnout_states[idx];
        REQ_FEEDBACK: begin
          run.push_back(tx_word(TX_ACC_INFO_REQ, 1'b0));
          run.push_back(tx_word(idx[9:2], 1'b0));
          run.push_back(tx_word(TX_LO_BASE | {7'd0, idx[1]}, 1'b1));
          req_open     = 1'b1;
          req_is_power = 1'b0;
          req_module   = idx[9:1];
        end
        REQ_POWER: begin
          run.push_back(tx_word(TX_STATUS_HDR, 1'b0));
          run.push_back(tx_word(TX_STATUS_ID, 1'b1));
          req_open     = 1'b1;
          req_is_power = 1'b1;
        end
        REQ_TURNOUT: begin
          if (power_on) begin
            run.push_back(tx_word(TX_ACC_OP, 1'b0));
            run.push_back(tx_word(idx[9:2], 1'b0));
            run.push_back(tx_word(TX_LO_PRESS | {5'd0, lo}, 1'b1));
            run.push_back(tx_word(TX_ACC_OP, 1'b0));
            run.push_back(tx_word(idx[9:2], 1'b0));
            run.push_back(tx_word(TX_LO_BASE | {5'd0, lo}, 1'b1));
          end
        end
        default: ;
      endcase
      if (run.size() == 0) run.push_back(bus_result_t'(0));
      foreach (run[k]) begin
        run[k].turnout_value = tval;
        run[k].power_flag    = power_on;
        run[k].answered      = !req_open;
        run[k].busy          = busy;
        run[k].run_last      = (k == run.size() - 1);
        awaited_results.push_back(run[k]);
      end
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] seen);
      if (seen !== want) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, seen);
        errors++;
      end
    endfunction

    function void check_result(bus_result_t got);
      bus_result_t want;
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0h", $time, got);
        errors++;
        return;
      end
      want = awaited_results.pop_front();
      compare_field("tx_valid", 8'(want.tx_valid), 8'(got.tx_valid));
      compare_field("tx_byte", want.tx_byte, got.tx_byte);
      compare_field("tx_msg_end", 8'(want.tx_msg_end), 8'(got.tx_msg_end));
      compare_field("turnout_value", 8'(want.turnout_value), 8'(got.turnout_value));
      compare_field("power_flag", 8'(want.power_flag), 8'(got.power_flag));
      compare_field("request_answered", 8'(want.answered), 8'(got.answered));
      compare_field("busy_pulse", 8'(want.busy), 8'(got.busy));
      compare_field("run_last", 8'(want.run_last), 8'(got.run_last));
    endfunction
  endclass

endpackage

module accessory_bus_message_handler_tb;
  import abmh_pkg::*;
  import abmh_tb_pkg::*;

  localparam int RANDOM_REQUESTS = 38;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int DRAIN_CYCLES    = 16;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  in_req_type;
  logic [7:0]  in_rx_byte;
  logic        in_rx_end;
  logic [10:0] in_accessory_number;
  logic        in_turn_direction;
  logic        out_valid;
  logic        out_stall;
  logic        out_tx_valid;
  logic [7:0]  out_tx_byte;
  logic        out_tx_msg_end;
  logic [1:0]  out_turnout_value;
  logic        out_power_flag;
  logic        out_request_answered;
  logic        out_busy_pulse;
  logic        out_run_last;

  int          sender_idle_pct;
  int          receiver_stall_pct;
  int          sent;
  logic [8:0]  hot_module;
  accessory_bus_scoreboard sb;

  wire in_fire  = in_valid && !in_stall;
  wire out_fire = out_valid && !out_stall;

  accessory_bus_message_handler DUT (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_req_type          (in_req_type),
    .in_rx_byte           (in_rx_byte),
    .in_rx_end            (in_rx_end),
    .in_accessory_number  (in_accessory_number),
    .in_turn_direction    (in_turn_direction),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_tx_valid         (out_tx_valid),
    .out_tx_byte          (out_tx_byte),
    .out_tx_msg_end       (out_tx_msg_end),
    .out_turnout_value    (out_turnout_value),
    .out_power_flag       (out_power_flag),
    .out_request_answered (out_request_answered),
    .out_busy_pulse       (out_busy_pulse),
    .out_run_last         (out_run_last)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Receiver back-pressure
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99, 0) < receiver_stall_pct);
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_fire) begin
      sb.check_result('{out_tx_valid, out_tx_byte, out_tx_msg_end, out_turnout_value,
                        out_power_flag, out_request_answered, out_busy_pulse, out_run_last});
    end
  end

  // Give up once the channels have been quiet for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (in_fire || out_fire) quiet = 0;
      else quiet++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // Drive one request and hold it until taken
  task automatic send(input logic [2:0] kind, input logic [7:0] b, input logic last,
                      input logic [10:0] acc, input logic dir);
    bus_req_t req;
    req = '{kind, b, last, acc, dir};
    while ($urandom_range(99, 0) < sender_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
      @(posedge clk);
    end
    @(negedge clk);
    in_valid            <= 1'b1;
    in_req_type         <= kind;
    in_rx_byte          <= b;
    in_rx_end           <= last;
    in_accessory_number <= acc;
    in_turn_direction   <= dir;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.apply_request(req);
    sent++;
  endtask

  // Received bus byte; the unused fields carry noise
  task automatic rx(input logic [7:0] b, input logic last);
    send(REQ_RX_BYTE, b, last, 11'($urandom), 1'($urandom));
  endtask

  task automatic ask(input logic [2:0] kind, input logic [10:0] acc, input logic dir);
    send(kind, 8'($urandom), 1'($urandom), acc, dir);
  endtask

  // Mostly in range, often near the module last asked about, now and then anything
  function automatic logic [10:0] pick_acc();
    int r;
    r = $urandom_range(9, 0);
    if (r == 0) return 11'($urandom_range(2047, 0));
    if (r < 5) return {1'b0, hot_module, 1'($urandom)} + 11'd1;
    return 11'($urandom_range(1024, 1));
  endfunction

  // One random message or request, mostly well formed
  task automatic send_random_message();
    int          pick;
    int          n;
    logic        aim;
    logic [7:0]  b;
    logic [7:0]  id;
    logic [10:0] acc;
    logic [9:0]  idx;
    aim  = 1'b0;
    pick = $urandom_range(19, 0);
    if (pick < 7) begin
      // accessory frame, sometimes cut to an odd length
      if ($urandom_range(3, 0) == 0) n = $urandom_range(6, 1);
      else n = 2 + 2 * $urandom_range(3, 0);
      rx(HDR_ACC_INFO, n == 1);
      for (int k = 1; k < n; k++) begin
        b = 8'($urandom);
        if (k % 2 == 1) aim = ($urandom_range(1, 0) == 1);
        if (aim && k % 2 == 1) b = hot_module[8:1];
        if (aim && k % 2 == 0) b[4] = hot_module[0];
        rx(b, k == n - 1);
      end
    end else if (pick < 10) begin
      // broadcast, three bytes in most cases
      n = ($urandom_range(4, 0) == 0) ? $urandom_range(4, 2) : 3;
      case ($urandom_range(5, 0))
        0, 1:    begin b = HDR_BCAST; id = ID_TRACK_ON;  end
        2:       begin b = HDR_BCAST; id = ID_TRACK_OFF; end
        3:       begin b = HDR_BCAST; id = ID_PROG_MODE; end
        4:       begin b = HDR_BCAST; id = ID_BUSY;      end
        default: begin b = HDR_ESTOP; id = ID_TRACK_OFF; end
      endcase
      rx(b, 1'b0);
      rx(id, n == 2);
      for (int k = 2; k < n; k++) rx(8'($urandom), k == n - 1);
    end else if (pick < 12) begin
      // track status reply
      n = ($urandom_range(4, 0) == 0) ? $urandom_range(5, 3) : 4;
      b = 8'($urandom);
      if ($urandom_range(1, 0) == 1) b = b & ~STATUS_OFF_MASK;
      rx(HDR_STATUS, 1'b0);
      rx(ID_STATUS, 1'b0);
      rx(b, n == 3);
      for (int k = 3; k < n; k++) rx(8'($urandom), k == n - 1);
    end else if (pick < 14) begin
      acc        = pick_acc();
      idx        = 10'(acc - 11'd1);
      hot_module = idx[9:1];
      ask(REQ_FEEDBACK, acc, 1'($urandom));
    end else if (pick == 14) begin
      ask(REQ_POWER, pick_acc(), 1'($urandom));
    end else if (pick < 17) begin
      ask(REQ_TURNOUT, pick_acc(), 1'($urandom));
    end else if (pick == 17) begin
      ask(REQ_READ, pick_acc(), 1'($urandom));
    end else if (pick == 18) begin
      // noise message
      n = $urandom_range(5, 1);
      for (int k = 0; k < n; k++) rx(8'($urandom), k == n - 1);
    end else begin
      send(3'($urandom_range(REQ_UNUSED_HI, REQ_UNUSED_LO)), 8'($urandom), 1'($urandom),
           11'($urandom), 1'($urandom));
    end
  endtask

  initial begin
    int start;
    int n;
    sb                  = new();
    rst_n               = 1'b0;
    in_valid            = 1'b0;
    in_req_type         = REQ_RX_BYTE;
    in_rx_byte          = '0;
    in_rx_end           = 1'b0;
    in_accessory_number = '0;
    in_turn_direction   = 1'b0;
    out_stall           = 1'b0;
    sent                = 0;
    hot_module          = '0;
    sender_idle_pct     = 12;
    receiver_stall_pct  = 84;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: cleared table, idle turnout action, ignored codes
    ask(REQ_READ, 11'd1, 1'b0);
    ask(REQ_TURNOUT, 11'h7FF, 1'b1);
    send(REQ_UNUSED_LO, 8'h00, 1'b0, 11'd0, 1'b0);
    send(REQ_UNUSED_HI, 8'hFF, 1'b1, 11'h7FF, 1'b1);
    // power request answered by a status reply that turns power on
    ask(REQ_POWER, 11'd512, 1'b0);
    rx(HDR_STATUS, 1'b0);
    rx(ID_STATUS, 1'b0);
    rx(8'hB4, 1'b0);
    rx(8'hA5, 1'b1);
    // turnout actions at both ends; zero wraps to the top entry
    ask(REQ_TURNOUT, 11'd1, 1'b0);
    ask(REQ_TURNOUT, 11'd0, 1'b1);
    // feedback request for the top module, answered by a frame with one pair
    ask(REQ_FEEDBACK, 11'h7FF, 1'b0);
    rx(HDR_ACC_INFO, 1'b0);
    rx(8'hFF, 1'b0);
    rx(8'h19, 1'b0);
    rx(8'h00, 1'b1);
    ask(REQ_READ, 11'd1023, 1'b1);
    ask(REQ_READ, 11'd1024, 1'b0);
    // busy announcement, then power off
    rx(HDR_BCAST, 1'b0);
    rx(ID_BUSY, 1'b0);
    rx(8'hE0, 1'b1);
    rx(HDR_BCAST, 1'b0);
    rx(ID_TRACK_OFF, 1'b0);
    rx(8'h61, 1'b1);

    // Overlong accessory frame: bytes past the length cap are dropped
    n = $urandom_range(70, 65);
    rx(HDR_ACC_INFO, 1'b0);
    for (int k = 1; k < n; k++) rx(8'($urandom), k == n - 1);

    // Random traffic in three idling phases
    start = sent;
    while (sent - start < RANDOM_REQUESTS) begin
      case ((sent - start) * 3 / RANDOM_REQUESTS)
        0:       begin sender_idle_pct = 12; receiver_stall_pct = 84; end
        1:       begin sender_idle_pct = 84; receiver_stall_pct = 12; end
        default: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
      endcase
      send_random_message();
    end
    @(negedge clk);
    in_valid <= 1'b0;

    // Drain
    while (sb.waiting() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

### files.f
hdl/abmh_pkg.sv
hdl/abmh_core.sv
hdl/abmh_tx_seq.sv
hdl/accessory_bus_message_handler.sv
hdl/abmh_checker.sv
test/accessory_bus_message_handler_tb.sv
